@@ rtl/bost_pkg.sv @@
// Package for the block offset sum tree: field widths, request and status
// codes, and the packed request and response items.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bost_pkg;

  localparam int REQ_TYPE_W = 3;
  localparam int VOFF_W     = 42;
  localparam int IDX_W      = 11;
  localparam int SIZE_W     = 32;
  localparam int ROFF_W     = 32;
  localparam int STATUS_W   = 2;
  localparam int FOUND_W    = 10;
  localparam int ROUT_W     = 33;
  localparam int TOTAL_W    = 42;
  localparam int CNT_OUT_W  = 11;

  // Width of one tree node and of one block table word (real offset, size).
  localparam int NODE_W = 42;
  localparam int BLK_W  = ROFF_W + SIZE_W;

  typedef enum logic [REQ_TYPE_W-1:0] {
    REQ_TRANSLATE = 3'd0,
    REQ_RESIZE    = 3'd1,
    REQ_INSERT    = 3'd2,
    REQ_REMOVE    = 3'd3,
    REQ_FETCH     = 3'd4,
    REQ_TOTALS    = 3'd5
  } req_type_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_RANGE     = 2'd1,
    STATUS_BAD_INDEX = 2'd2
  } status_e;

  typedef struct packed {
    logic [REQ_TYPE_W-1:0] req_type;
    logic [VOFF_W-1:0]     virt_offset;
    logic [IDX_W-1:0]      block_index;
    logic [SIZE_W-1:0]     new_size;
    logic [ROFF_W-1:0]     block_real_offset;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [FOUND_W-1:0]   found_index;
    logic [ROUT_W-1:0]    phys_offset;
    logic [SIZE_W-1:0]    out_block_size;
    logic [TOTAL_W-1:0]   total_size;
    logic [CNT_OUT_W-1:0] block_total;
  } rsp_t;

endpackage

`default_nettype wire

@@ rtl/bost_chan_if.sv @@
// Valid/ready channel carrying one item of a payload type.
// No dependencies; the payload type is chosen where the channel is declared.
`timescale 1ns / 1ps
`default_nettype none

interface bost_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/block_offset_sum_tree_unit.sv @@
// Top level of the block offset sum tree: block table RAM, sum tree RAM and
// the sequencer that walks, updates, shifts and rebuilds them.
// Depends on bost_pkg, bost_chan_if and bost_ram.
`timescale 1ns / 1ps
`default_nettype none

// One request is worked at a time; its response sits in an output register,
// so the next request is taken while that response waits. Each cycle makes
// at most one access to the sum tree RAM or the block table RAM. LEVELS is
// the tree depth, 6 at the defaults, and NNODES the node count, 1365 at the
// defaults. Translate reads and then weighs one child at a time. Resize
// writes the block word, then reads and writes one node per level from the
// root down. Insert and delete shift the blocks one by one, a read and then
// a write each, then run a bottom-up rebuild of every node. After reset the
// same rebuild pass clears the tree; no request is taken during that pass.
module block_offset_sum_tree_unit #(
  parameter int MAX_BLOCKS = 1024,
  parameter int FANOUT     = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bost_chan_if.sink   req_i,
  bost_chan_if.source rsp_o
);

  function automatic int calc_levels();
    int     l;
    longint t;
    l = 1;
    t = FANOUT;
    for (int i = 0; i < 30; i++) begin
      if (t <= MAX_BLOCKS) begin
        l++;
        t = t * FANOUT;
      end
    end
    return l;
  endfunction

  localparam int LEVELS = calc_levels();

  function automatic longint calc_nodes();
    longint n;
    longint w;
    n = 0;
    w = 1;
    for (int j = 0; j < LEVELS; j++) begin
      n = n + w;
      w = w * FANOUT;
    end
    return n;
  endfunction

  localparam int NNODES  = int'(calc_nodes());
  localparam int NODE_AW = $clog2(NNODES);
  localparam int CHILD_W = $clog2(NNODES * FANOUT + 1);
  localparam int BLK_AW  = $clog2(MAX_BLOCKS);
  localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
  localparam int IW      = (CNT_W > bost_pkg::IDX_W) ? CNT_W : bost_pkg::IDX_W;
  localparam int LVL_W   = $clog2(LEVELS);
  localparam int DIG_W   = $clog2(FANOUT);
  localparam int THR_W   = $clog2(FANOUT * MAX_BLOCKS + 1);
  localparam int BASE_W  = bost_pkg::NODE_W + $clog2(LEVELS * FANOUT) + 1;
  localparam int SUM_W   = BASE_W + 1;
  localparam int NODE_W  = bost_pkg::NODE_W;

  localparam logic [CHILD_W-1:0] CB_LAST = CHILD_W'((NNODES - 1) * FANOUT + 1);

  typedef logic [THR_W-1:0] span_tbl_t [LEVELS];

  // Blocks covered by one child of a node at each level.
  function automatic span_tbl_t calc_spans();
    span_tbl_t s;
    longint    w;
    w = 1;
    for (int j = LEVELS - 1; j >= 0; j--) begin
      s[j] = THR_W'(w);
      w = w * FANOUT;
    end
    return s;
  endfunction

  localparam span_tbl_t SPAN_TBL = calc_spans();

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_TR_RD  = 4'd1;
  localparam logic [3:0] ST_TR_EV  = 4'd2;
  localparam logic [3:0] ST_RS_BW  = 4'd3;
  localparam logic [3:0] ST_RS_NRD = 4'd4;
  localparam logic [3:0] ST_RS_NWR = 4'd5;
  localparam logic [3:0] ST_SH_RD  = 4'd6;
  localparam logic [3:0] ST_SH_WR  = 4'd7;
  localparam logic [3:0] ST_INS_WR = 4'd8;
  localparam logic [3:0] ST_RB_RD  = 4'd9;
  localparam logic [3:0] ST_RB_WR  = 4'd10;
  localparam logic [3:0] ST_RD_EV  = 4'd11;
  localparam logic [3:0] ST_DONE   = 4'd12;

  // Control registers.
  logic [3:0]         state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [NODE_W-1:0]  root_q, root_d;
  logic [NODE_AW-1:0] k_q, k_d;
  logic [CHILD_W-1:0] cb_q, cb_d;
  logic [DIG_W-1:0]   c_q, c_d;
  logic [LVL_W-1:0]   lvl_q, lvl_d;
  logic               pend_q, pend_d;
  logic               rb_rsp_q, rb_rsp_d;
  logic               ov_q, ov_d;

  // Payload and working registers.
  bost_pkg::req_t     req_q, req_d;
  bost_pkg::rsp_t     rsp_q, rsp_d;
  logic [THR_W-1:0]   rem_q, rem_d;
  logic [BASE_W-1:0]  base_q, base_d;
  logic [NODE_W-1:0]  delta_q, delta_d;
  logic [NODE_W-1:0]  acc_q, acc_d;
  logic               leaf_q, leaf_d;
  logic               pend_valid_q, pend_valid_d;
  logic [BLK_AW-1:0]  src_q, src_d;
  logic               shift_up_q, shift_up_d;
  logic [1:0]         res_status_q, res_status_d;
  logic [9:0]         res_found_q, res_found_d;
  logic [32:0]        res_roff_q, res_roff_d;
  logic [31:0]        res_osz_q, res_osz_d;

  // RAM ports.
  logic               t_we, t_re;
  logic [NODE_AW-1:0] t_waddr, t_raddr;
  logic [NODE_W-1:0]  t_wdata, t_rdata;
  logic               b_we, b_re;
  logic [BLK_AW-1:0]  b_waddr, b_raddr;
  logic [bost_pkg::BLK_W-1:0] b_wdata, b_rdata;

  bost_ram #(.WIDTH(NODE_W), .DEPTH(NNODES)) u_tree_ram (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (t_waddr),
    .wdata_i (t_wdata),
    .re_i    (t_re),
    .raddr_i (t_raddr),
    .rdata_o (t_rdata)
  );

  bost_ram #(.WIDTH(bost_pkg::BLK_W), .DEPTH(MAX_BLOCKS)) u_blk_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (b_wdata),
    .re_i    (b_re),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  // Child under consideration and whether it is a block rather than a node.
  logic [CHILD_W-1:0] ci, blk_ci, ci_desc;
  logic               is_leaf, blk_ok;
  logic [31:0]        b_size, b_roff;

  assign ci      = cb_q + CHILD_W'(c_q);
  assign is_leaf = (ci >= CHILD_W'(NNODES));
  assign blk_ci  = ci - CHILD_W'(NNODES);
  assign blk_ok  = (blk_ci < CHILD_W'(count_q));
  assign ci_desc = ci * CHILD_W'(FANOUT) + CHILD_W'(1);
  assign b_size  = b_rdata[31:0];
  assign b_roff  = b_rdata[63:32];

  // Child digit of the resized block at the current level.
  logic [THR_W-1:0] span_sel, dig_thr;
  logic [DIG_W-1:0] dig;

  assign span_sel = SPAN_TBL[lvl_q];

  always_comb begin
    dig     = '0;
    dig_thr = '0;
    for (int c = 1; c < FANOUT; c++) begin
      if (rem_q >= span_sel * THR_W'(c)) begin
        dig     = DIG_W'(c);
        dig_thr = span_sel * THR_W'(c);
      end
    end
  end

  // Translate compare and rebuild accumulate.
  logic [SUM_W-1:0]   tr_val, tr_sum, voff_ext, tr_diff;
  logic               tr_hit;
  logic [NODE_W-1:0]  rb_val, rb_final, rs_new;
  logic [CHILD_W-1:0] nk_wide;

  assign tr_val   = leaf_q ? SUM_W'(b_size) : SUM_W'(t_rdata);
  assign tr_sum   = SUM_W'(base_q) + tr_val;
  assign voff_ext = SUM_W'(req_q.virt_offset);
  assign tr_hit   = (voff_ext < tr_sum);
  assign tr_diff  = voff_ext - SUM_W'(base_q);
  assign rb_val   = leaf_q ? (pend_valid_q ? NODE_W'(b_size) : '0) : t_rdata;
  assign rb_final = acc_q + rb_val;
  assign rs_new   = t_rdata + delta_q;
  assign nk_wide  = CHILD_W'(k_q) * CHILD_W'(FANOUT) + CHILD_W'(dig) + CHILD_W'(1);

  bost_pkg::req_t req_in;
  logic [IW-1:0]  idx_in, cnt_ext;

  assign req_in  = req_i.payload;
  assign idx_in  = IW'(req_in.block_index);
  assign cnt_ext = IW'(count_q);

  assign req_i.ready   = (state_q == ST_IDLE);
  assign rsp_o.valid   = ov_q;
  assign rsp_o.payload = rsp_q;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    root_d       = root_q;
    k_d          = k_q;
    cb_d         = cb_q;
    c_d          = c_q;
    lvl_d        = lvl_q;
    pend_d       = pend_q;
    rb_rsp_d     = rb_rsp_q;
    ov_d         = ov_q;
    req_d        = req_q;
    rsp_d        = rsp_q;
    rem_d        = rem_q;
    base_d       = base_q;
    delta_d      = delta_q;
    acc_d        = acc_q;
    leaf_d       = leaf_q;
    pend_valid_d = pend_valid_q;
    src_d        = src_q;
    shift_up_d   = shift_up_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    res_roff_d   = res_roff_q;
    res_osz_d    = res_osz_q;
    t_we    = 1'b0;
    t_waddr = k_q;
    t_wdata = '0;
    t_re    = 1'b0;
    t_raddr = NODE_AW'(ci);
    b_we    = 1'b0;
    b_waddr = src_q;
    b_wdata = b_rdata;
    b_re    = 1'b0;
    b_raddr = src_q;

    if (ov_q && rsp_o.ready) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          req_d        = req_in;
          res_status_d = bost_pkg::STATUS_OK;
          res_found_d  = '0;
          res_roff_d   = '0;
          res_osz_d    = '0;
          unique case (req_in.req_type)
            bost_pkg::REQ_TRANSLATE: begin
              if (req_in.virt_offset >= root_q) begin
                res_status_d = bost_pkg::STATUS_RANGE;
                state_d      = ST_DONE;
              end else begin
                base_d  = '0;
                cb_d    = CHILD_W'(1);
                c_d     = '0;
                state_d = ST_TR_RD;
              end
            end
            bost_pkg::REQ_RESIZE: begin
              if (idx_in >= cnt_ext) begin
                res_status_d = bost_pkg::STATUS_BAD_INDEX;
                state_d      = ST_DONE;
              end else begin
                b_re    = 1'b1;
                b_raddr = BLK_AW'(idx_in);
                state_d = ST_RS_BW;
              end
            end
            bost_pkg::REQ_INSERT: begin
              if (idx_in > cnt_ext || count_q >= CNT_W'(MAX_BLOCKS)) begin
                res_status_d = bost_pkg::STATUS_BAD_INDEX;
                state_d      = ST_DONE;
              end else if (idx_in == cnt_ext) begin
                state_d = ST_INS_WR;
              end else begin
                src_d      = BLK_AW'(count_q - CNT_W'(1));
                shift_up_d = 1'b1;
                state_d    = ST_SH_RD;
              end
            end
            bost_pkg::REQ_REMOVE: begin
              if (idx_in >= cnt_ext) begin
                res_status_d = bost_pkg::STATUS_BAD_INDEX;
                state_d      = ST_DONE;
              end else if (idx_in + IW'(1) == cnt_ext) begin
                count_d  = count_q - CNT_W'(1);
                k_d      = NODE_AW'(NNODES - 1);
                cb_d     = CB_LAST;
                c_d      = '0;
                acc_d    = '0;
                pend_d   = 1'b0;
                rb_rsp_d = 1'b1;
                state_d  = ST_RB_RD;
              end else begin
                src_d      = BLK_AW'(idx_in + IW'(1));
                shift_up_d = 1'b0;
                state_d    = ST_SH_RD;
              end
            end
            bost_pkg::REQ_FETCH: begin
              if (idx_in >= cnt_ext) begin
                res_status_d = bost_pkg::STATUS_BAD_INDEX;
                state_d      = ST_DONE;
              end else begin
                b_re    = 1'b1;
                b_raddr = BLK_AW'(idx_in);
                state_d = ST_RD_EV;
              end
            end
            default: begin
              // Totals, and the unused request codes, report the totals only.
              state_d = ST_DONE;
            end
          endcase
        end
      end

      ST_TR_RD: begin
        leaf_d = is_leaf;
        if (is_leaf) begin
          if (!blk_ok) begin
            res_status_d = bost_pkg::STATUS_RANGE;
            state_d      = ST_DONE;
          end else begin
            b_re    = 1'b1;
            b_raddr = BLK_AW'(blk_ci);
            state_d = ST_TR_EV;
          end
        end else begin
          t_re    = 1'b1;
          t_raddr = NODE_AW'(ci);
          state_d = ST_TR_EV;
        end
      end

      ST_TR_EV: begin
        if (leaf_q) begin
          if (tr_hit) begin
            res_found_d = 10'(blk_ci);
            res_roff_d  = 33'(b_roff) + tr_diff[32:0];
            state_d     = ST_DONE;
          end else if (c_q == DIG_W'(FANOUT - 1)) begin
            res_status_d = bost_pkg::STATUS_RANGE;
            state_d      = ST_DONE;
          end else begin
            base_d  = BASE_W'(tr_sum);
            c_d     = c_q + DIG_W'(1);
            state_d = ST_TR_RD;
          end
        end else begin
          // With wrapped sums no child may match; the last child is taken.
          if (tr_hit || c_q == DIG_W'(FANOUT - 1)) begin
            cb_d = ci_desc;
            c_d  = '0;
          end else begin
            base_d = BASE_W'(tr_sum);
            c_d    = c_q + DIG_W'(1);
          end
          state_d = ST_TR_RD;
        end
      end

      ST_RS_BW: begin
        delta_d = NODE_W'(req_q.new_size) - NODE_W'(b_size);
        b_we    = 1'b1;
        b_waddr = BLK_AW'(req_q.block_index);
        b_wdata = {b_roff, req_q.new_size};
        k_d     = '0;
        lvl_d   = '0;
        rem_d   = THR_W'(req_q.block_index);
        state_d = ST_RS_NRD;
      end

      ST_RS_NRD: begin
        t_re    = 1'b1;
        t_raddr = k_q;
        state_d = ST_RS_NWR;
      end

      ST_RS_NWR: begin
        t_we    = 1'b1;
        t_waddr = k_q;
        t_wdata = rs_new;
        if (k_q == '0) begin
          root_d = rs_new;
        end
        if (lvl_q == LVL_W'(LEVELS - 1)) begin
          state_d = ST_DONE;
        end else begin
          k_d     = nk_wide[NODE_AW-1:0];
          rem_d   = rem_q - dig_thr;
          lvl_d   = lvl_q + LVL_W'(1);
          state_d = ST_RS_NRD;
        end
      end

      ST_SH_RD: begin
        b_re    = 1'b1;
        b_raddr = src_q;
        state_d = ST_SH_WR;
      end

      ST_SH_WR: begin
        b_we    = 1'b1;
        b_wdata = b_rdata;
        if (shift_up_q) begin
          b_waddr = src_q + BLK_AW'(1);
          if (src_q == BLK_AW'(req_q.block_index)) begin
            state_d = ST_INS_WR;
          end else begin
            src_d   = src_q - BLK_AW'(1);
            state_d = ST_SH_RD;
          end
        end else begin
          b_waddr = src_q - BLK_AW'(1);
          if (src_q == BLK_AW'(count_q - CNT_W'(1))) begin
            count_d  = count_q - CNT_W'(1);
            k_d      = NODE_AW'(NNODES - 1);
            cb_d     = CB_LAST;
            c_d      = '0;
            acc_d    = '0;
            pend_d   = 1'b0;
            rb_rsp_d = 1'b1;
            state_d  = ST_RB_RD;
          end else begin
            src_d   = src_q + BLK_AW'(1);
            state_d = ST_SH_RD;
          end
        end
      end

      ST_INS_WR: begin
        b_we     = 1'b1;
        b_waddr  = BLK_AW'(req_q.block_index);
        b_wdata  = {req_q.block_real_offset, req_q.new_size};
        count_d  = count_q + CNT_W'(1);
        k_d      = NODE_AW'(NNODES - 1);
        cb_d     = CB_LAST;
        c_d      = '0;
        acc_d    = '0;
        pend_d   = 1'b0;
        rb_rsp_d = 1'b1;
        state_d  = ST_RB_RD;
      end

      ST_RB_RD: begin
        // Children have higher indexes than their parent, so walking the
        // nodes downward always finds the children already rebuilt. The
        // first child of a node starts the sum from zero.
        acc_d  = pend_q ? (acc_q + rb_val) : '0;
        pend_d = 1'b1;
        leaf_d = is_leaf;
        if (is_leaf) begin
          b_re         = 1'b1;
          b_raddr      = BLK_AW'(blk_ci);
          pend_valid_d = blk_ok;
        end else begin
          t_re         = 1'b1;
          t_raddr      = NODE_AW'(ci);
          pend_valid_d = 1'b1;
        end
        if (c_q == DIG_W'(FANOUT - 1)) begin
          state_d = ST_RB_WR;
        end else begin
          c_d = c_q + DIG_W'(1);
        end
      end

      ST_RB_WR: begin
        t_we    = 1'b1;
        t_waddr = k_q;
        t_wdata = rb_final;
        pend_d  = 1'b0;
        if (k_q == '0) begin
          root_d  = rb_final;
          state_d = rb_rsp_q ? ST_DONE : ST_IDLE;
        end else begin
          k_d     = k_q - NODE_AW'(1);
          cb_d    = cb_q - CHILD_W'(FANOUT);
          c_d     = '0;
          acc_d   = '0;
          state_d = ST_RB_RD;
        end
      end

      ST_RD_EV: begin
        res_roff_d = 33'(b_roff);
        res_osz_d  = b_size;
        state_d    = ST_DONE;
      end

      ST_DONE: begin
        if (!ov_q || rsp_o.ready) begin
          rsp_d.status         = res_status_q;
          rsp_d.found_index    = res_found_q;
          rsp_d.phys_offset    = res_roff_q;
          rsp_d.out_block_size = res_osz_q;
          rsp_d.total_size     = root_q;
          rsp_d.block_total    = bost_pkg::CNT_OUT_W'(count_q);
          ov_d                 = 1'b1;
          state_d              = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // After reset the rebuild pass runs with no blocks and zeroes the tree.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_RB_RD;
      count_q  <= '0;
      root_q   <= '0;
      k_q      <= NODE_AW'(NNODES - 1);
      cb_q     <= CB_LAST;
      c_q      <= '0;
      lvl_q    <= '0;
      pend_q   <= 1'b0;
      rb_rsp_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      root_q   <= root_d;
      k_q      <= k_d;
      cb_q     <= cb_d;
      c_q      <= c_d;
      lvl_q    <= lvl_d;
      pend_q   <= pend_d;
      rb_rsp_q <= rb_rsp_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    rsp_q        <= rsp_d;
    rem_q        <= rem_d;
    base_q       <= base_d;
    delta_q      <= delta_d;
    acc_q        <= acc_d;
    leaf_q       <= leaf_d;
    pend_valid_q <= pend_valid_d;
    src_q        <= src_d;
    shift_up_q   <= shift_up_d;
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    res_roff_q   <= res_roff_d;
    res_osz_q    <= res_osz_d;
  end

endmodule

`default_nettype wire

@@ rtl/bost_ram.sv @@
// Generic RAM: one write port and one read port with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bost_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
